[src/pfe_pkg.sv]
// Shared types and codes for the page-mode framebuffer pixel engine.
// Used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

  // command codes on the cmd field
  localparam logic [2:0] CMD_DRAW   = 3'd0;
  localparam logic [2:0] CMD_GLYPH  = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // pixel codes on the color field
  localparam logic [1:0] PIX_OFF  = 2'd0;
  localparam logic [1:0] PIX_ON   = 2'd1;
  localparam logic [1:0] PIX_FLIP = 2'd2;

  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd126;

  // configuration register indexes and reset values
  localparam logic [1:0] REG_FONT_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FONT_HEIGHT = 2'd1;
  localparam logic [4:0] FONT_WIDTH_RESET  = 5'd7;
  localparam logic [6:0] FONT_HEIGHT_RESET = 7'd10;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_FAIL,
    OP_PLOT,
    OP_GLYPH,
    OP_CURSOR,
    OP_CLEAR,
    OP_READ
  } pfe_op_t;

  typedef struct packed {
    pfe_op_t     op;
    logic [7:0]  x;
    logic [6:0]  y;
    logic [1:0]  color;
    logic [15:0] row_bits;
    logic [5:0]  row_index;
  } pfe_entry_t;

  typedef struct packed {
    logic [4:0] font_width;
    logic [6:0] font_height;
  } pfe_cfg_t;

endpackage

`default_nettype wire

[src/pfe_front.sv]
// Front end: accepts input transactions and classifies each into a queue entry.
// Checks bounds, glyph code range and glyph row index. Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfe_front #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        cmd,
  input  wire logic [7:0]        x,
  input  wire logic [6:0]        y,
  input  wire logic [1:0]        color,
  input  wire logic [7:0]        char_code,
  input  wire logic [15:0]       row_bits,
  input  wire logic [5:0]        row_index,
  input  wire pfe_pkg::pfe_cfg_t cfg,
  input  wire logic              q_full,
  input  wire logic              init_busy,
  output logic                   push,
  output pfe_pkg::pfe_entry_t    push_entry
);
  import pfe_pkg::*;

  logic x_ok;
  logic y_ok;
  logic char_ok;
  logic row_ok;

  assign x_ok    = {1'b0, x} < 9'(WIDTH);
  assign y_ok    = {1'b0, y} < 8'(HEIGHT);
  assign char_ok = (char_code >= CHAR_FIRST) && (char_code <= CHAR_LAST);
  assign row_ok  = {1'b0, row_index} < cfg.font_height;

  // nothing is taken while the queue is full or the store is being wiped after reset
  assign in_stall = q_full || init_busy;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_entry.x         = x;
    push_entry.y         = y;
    push_entry.color     = color;
    push_entry.row_bits  = row_bits;
    push_entry.row_index = row_index;
    case (cmd)
      CMD_DRAW:   push_entry.op = (x_ok && y_ok) ? OP_PLOT : OP_FAIL;
      CMD_GLYPH:  push_entry.op = (char_ok && row_ok) ? OP_GLYPH : OP_FAIL;
      CMD_CURSOR: push_entry.op = (x_ok && y_ok) ? OP_CURSOR : OP_FAIL;
      CMD_CLEAR:  push_entry.op = OP_CLEAR;
      CMD_READ:   push_entry.op = (x_ok && y_ok) ? OP_READ : OP_FAIL;
      default:    push_entry.op = OP_FAIL;
    endcase
  end

endmodule

`default_nettype wire

[src/pfe_queue.sv]
// Short command queue between the front end and the back end.
// Holds classified entries in order. Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfe_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire pfe_pkg::pfe_entry_t push_entry,
  output logic                     full,
  output logic                     head_valid,
  output pfe_pkg::pfe_entry_t      head_entry,
  input  wire logic                pop
);
  import pfe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  pfe_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/pfe_back.sv]
// Back end: executes queued commands on the frame store and the glyph cursor.
// Owns the byte memory, the clearing pass and the result register. Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfe_back #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pfe_pkg::pfe_cfg_t   cfg,
  input  wire logic                q_valid,
  input  wire pfe_pkg::pfe_entry_t q_entry,
  output logic                     q_pop,
  output logic                     init_busy,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     status,
  output logic [7:0]               read_data
);
  import pfe_pkg::*;

  localparam int FB_BYTES = WIDTH * ((HEIGHT + 7) / 8);
  localparam int ADDR_W   = $clog2(FB_BYTES);
  localparam int COL_W    = $clog2(WIDTH);
  localparam int ROW_W    = $clog2(HEIGHT);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(FB_BYTES - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CLEAR  = 4'b0010,
    ST_MODIFY = 4'b0100,
    ST_READ   = 4'b1000
  } back_state_t;

  function automatic logic [7:0] apply_color(input logic [7:0] b, input logic [2:0] bitsel,
                                             input logic [1:0] c);
    logic [7:0] m;
    m = 8'd1 << bitsel;
    case (c)
      PIX_OFF:  apply_color = b & ~m;
      PIX_ON:   apply_color = b | m;
      PIX_FLIP: apply_color = b ^ m;
      default:  apply_color = b;
    endcase
  endfunction

  back_state_t state;
  back_state_t state_next;

  logic [7:0]        mem [FB_BYTES];
  logic [7:0]        rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [7:0]        wr_byte;

  logic [ADDR_W-1:0] addr;
  logic [2:0]        bitsel;
  logic [1:0]        color;
  logic              glyph;
  logic              last_row;
  logic [15:0]       shreg;
  logic [4:0]        pix_left;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;

  logic              res_free;
  logic              res_load;
  logic [7:0]        grow;
  logic [ADDR_W-1:0] plot_addr;
  logic [ADDR_W-1:0] glyph_addr;
  logic              fit_fail;
  logic              glyph_go;
  logic              glyph_done;
  logic [1:0]        pix_color;

  assign res_free   = !out_valid || !out_stall;
  assign q_pop      = (state == ST_IDLE) && q_valid && res_free;
  assign grow       = 8'(cursor_row) + 8'(q_entry.row_index);
  assign plot_addr  = ADDR_W'(int'(q_entry.y[6:3]) * WIDTH + int'(q_entry.x));
  assign glyph_addr = ADDR_W'(int'(grow[7:3]) * WIDTH + int'(cursor_col));
  assign fit_fail   = (10'(cursor_col) + 10'(cfg.font_width) > 10'(WIDTH - 1)) ||
                      (9'(cursor_row) + 9'(cfg.font_height) > 9'(HEIGHT));
  assign glyph_go   = !fit_fail && (cfg.font_width != 5'd0);
  assign glyph_done = !glyph || (pix_left == 5'd1);

  // 0-bits of a glyph take the opposite colour; invert maps to black there
  assign pix_color = !glyph ? color :
                     shreg[15] ? color :
                     (color == PIX_OFF) ? PIX_ON : PIX_OFF;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr;
    wr_en   = 1'b0;
    wr_byte = 8'd0;
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          if (q_entry.op == OP_PLOT || q_entry.op == OP_READ) begin
            rd_en   = 1'b1;
            rd_addr = plot_addr;
          end else if (q_entry.op == OP_GLYPH && glyph_go) begin
            rd_en   = 1'b1;
            rd_addr = glyph_addr;
          end
        end
      end
      ST_MODIFY: begin
        wr_en   = 1'b1;
        wr_byte = apply_color(rd_data, bitsel, pix_color);
        // glyph pixels of one row sit in consecutive bytes: fetch the next while writing
        if (!glyph_done) begin
          rd_en   = 1'b1;
          rd_addr = addr + ADDR_W'(1);
        end
      end
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_entry.op)
            OP_PLOT:  state_next = ST_MODIFY;
            OP_READ:  state_next = ST_READ;
            OP_CLEAR: state_next = ST_CLEAR;
            OP_GLYPH: state_next = glyph_go ? ST_MODIFY : ST_IDLE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_MODIFY: state_next = glyph_done ? ST_IDLE : ST_MODIFY;
      ST_CLEAR:  state_next = (addr == ADDR_LAST) ? ST_IDLE : ST_CLEAR;
      ST_READ:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // a result transaction is loaded into the output register this cycle
  always_comb begin
    res_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_entry.op)
            OP_PLOT:  res_load = 1'b0;
            OP_READ:  res_load = 1'b0;
            OP_CLEAR: res_load = 1'b0;
            OP_GLYPH: res_load = !glyph_go;
            default:  res_load = 1'b1;  // set cursor and failed commands answer at once
          endcase
        end
      end
      ST_MODIFY: res_load = glyph_done;
      ST_CLEAR:  res_load = (addr == ADDR_LAST) && !init_busy;
      ST_READ:   res_load = 1'b1;
      default:   res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      init_busy  <= 1'b1;
      addr       <= '0;
      out_valid  <= 1'b0;
      cursor_col <= '0;
      cursor_row <= '0;
      glyph      <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= res_load || (out_valid && out_stall);
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            glyph <= (q_entry.op == OP_GLYPH) && glyph_go;
            color <= q_entry.color;
            case (q_entry.op)
              OP_PLOT: begin
                addr   <= plot_addr;
                bitsel <= q_entry.y[2:0];
              end
              OP_GLYPH: begin
                if (glyph_go) begin
                  addr     <= glyph_addr;
                  bitsel   <= grow[2:0];
                  shreg    <= q_entry.row_bits;
                  pix_left <= cfg.font_width;
                  last_row <= (7'(q_entry.row_index) + 7'd1) == cfg.font_height;
                end else begin
                  // zero font width on an otherwise good row is ok and plots nothing
                  status    <= fit_fail;
                  read_data <= 8'd0;
                end
              end
              OP_CURSOR: begin
                cursor_col <= q_entry.x[COL_W-1:0];
                cursor_row <= q_entry.y[ROW_W-1:0];
                status     <= 1'b0;
                read_data  <= 8'd0;
              end
              OP_CLEAR: begin
                addr <= '0;
              end
              OP_READ: ;
              default: begin
                status    <= 1'b1;
                read_data <= 8'd0;
              end
            endcase
          end
        end
        ST_MODIFY: begin
          addr     <= addr + ADDR_W'(1);
          shreg    <= shreg << 1;
          pix_left <= pix_left - 5'd1;
          if (glyph_done) begin
            status    <= 1'b0;
            read_data <= 8'd0;
            if (glyph && last_row) begin
              cursor_col <= COL_W'(10'(cursor_col) + 10'(cfg.font_width));
            end
          end
        end
        ST_CLEAR: begin
          addr <= addr + ADDR_W'(1);
          if (addr == ADDR_LAST) begin
            init_busy <= 1'b0;
            if (!init_busy) begin
              status    <= 1'b0;
              read_data <= 8'd0;
            end
          end
        end
        ST_READ: begin
          status    <= 1'b0;
          read_data <= rd_data;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/page_framebuffer_pixel_engine.sv]
// Page-mode framebuffer pixel engine. The back end takes a command from the queue only while
// idle and with the result register free, and ends it before taking the next: a draw or read
// does one store read, then its write or its answer; a glyph row does one read-modify-write per
// pixel, reading the next byte while writing, on the separate read and write ports of the store.
// Reset is synchronous; it then wipes all WIDTH*((HEIGHT+7)/8) bytes of the store (1024 by
// default) one byte a cycle, with in_stall high. Configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_pixel_engine #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [7:0]  x,
  input  wire logic [6:0]  y,
  input  wire logic [1:0]  color,
  input  wire logic [7:0]  char_code,
  input  wire logic [15:0] row_bits,
  input  wire logic [5:0]  row_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic [7:0]       read_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import pfe_pkg::*;

  pfe_cfg_t   cfg;
  logic       q_full;
  logic       init_busy;
  logic       push;
  pfe_entry_t push_entry;
  logic       q_valid;
  pfe_entry_t q_entry;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.font_width  <= FONT_WIDTH_RESET;
      cfg.font_height <= FONT_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FONT_WIDTH:  cfg.font_width  <= cfg_data[4:0];
        REG_FONT_HEIGHT: cfg.font_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  pfe_front #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .x         (x),
    .y         (y),
    .color     (color),
    .char_code (char_code),
    .row_bits  (row_bits),
    .row_index (row_index),
    .cfg       (cfg),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .push_entry(push_entry)
  );

  pfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .head_valid(q_valid),
    .head_entry(q_entry),
    .pop       (q_pop)
  );

  pfe_back #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .init_busy(init_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .read_data(read_data)
  );

endmodule

`default_nettype wire

[src/pfe_checker.sv]
// Port-level checks for the pixel engine, bound to the top level.
// Sees only the top-level ports; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module pfe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       status,
  input wire logic [7:0] read_data
);

  logic [3:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // transactions accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 4'd0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 4'd1;
    end else if (!in_acc && out_acc) begin
      pending <= pending - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_data))
    else $error("result changed or dropped while stalled");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> read_data == 8'd0)
    else $error("failed command returned nonzero data");

  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("input taken before the post-reset wipe");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result without an outstanding command");

endmodule

bind page_framebuffer_pixel_engine pfe_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .status   (status),
  .read_data(read_data)
);

`default_nettype wire

[tb/pfe_frame_checker.sv]
// Checker for the page-mode framebuffer pixel engine: watches the command, result and
// configuration channels, keeps its own copy of the frame and cursor, and compares results.
// Depends on pfe_pkg for command, colour and register codes.
`timescale 1ns / 1ps

module pfe_frame_checker #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [7:0]  x,
  input  logic [6:0]  y,
  input  logic [1:0]  color,
  input  logic [7:0]  char_code,
  input  logic [15:0] row_bits,
  input  logic [5:0]  row_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        status,
  input  logic [7:0]  read_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  import pfe_pkg::*;

  localparam int FB_BYTES = WIDTH * ((HEIGHT + 7) / 8);

  typedef struct {
    logic       status;
    logic [7:0] read_data;
  } reply_t;

  logic [7:0] frame_mem [FB_BYTES];
  logic [6:0] cur_col;
  logic [5:0] cur_row;
  logic [4:0] font_w;
  logic [6:0] font_h;
  reply_t     reply_q [$];
  int         results_seen;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic plot_pixel(input int px, input int py, input logic [1:0] c);
    int         idx;
    logic [7:0] mask;
    if (px >= WIDTH || py >= HEIGHT) return 1'b1;
    idx  = px + (py / 8) * WIDTH;
    mask = 8'(1 << (py % 8));
    case (c)
      PIX_OFF:  frame_mem[idx] = frame_mem[idx] & ~mask;
      PIX_ON:   frame_mem[idx] = frame_mem[idx] | mask;
      PIX_FLIP: frame_mem[idx] = frame_mem[idx] ^ mask;
      default: ;  // unused code leaves the pixel alone
    endcase
    return 1'b0;
  endfunction

  function automatic logic draw_glyph_row(input logic [7:0] code, input logic [15:0] bits,
                                          input logic [5:0] ri, input logic [1:0] c);
    logic [1:0] other;
    logic       on;
    int         col;
    int         row;
    other = (c == PIX_OFF) ? PIX_ON : PIX_OFF;
    col   = int'(cur_col);
    row   = int'(cur_row);
    if (code < CHAR_FIRST || code > CHAR_LAST) return 1'b1;
    if (col + int'(font_w) > WIDTH - 1 || row + int'(font_h) > HEIGHT) return 1'b1;
    if (int'(ri) >= int'(font_h)) return 1'b1;
    for (int j = 0; j < int'(font_w); j++) begin
      on = (j < 16) ? bits[15 - j] : 1'b0;
      void'(plot_pixel(col + j, row + int'(ri), on ? c : other));
    end
    if (int'(ri) == int'(font_h) - 1) cur_col = 7'(col + int'(font_w));
    return 1'b0;
  endfunction

  function automatic reply_t run_command();
    reply_t r;
    r.status    = 1'b1;
    r.read_data = 8'h00;
    case (cmd)
      CMD_DRAW:  r.status = plot_pixel(int'(x), int'(y), color);
      CMD_GLYPH: r.status = draw_glyph_row(char_code, row_bits, row_index, color);
      CMD_CURSOR: begin
        if (int'(x) < WIDTH && int'(y) < HEIGHT) begin
          cur_col  = 7'(x);
          cur_row  = 6'(y);
          r.status = 1'b0;
        end
      end
      CMD_CLEAR: begin
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
        r.status = 1'b0;
      end
      CMD_READ: begin
        if (int'(x) < WIDTH && int'(y) < HEIGHT) begin
          r.read_data = frame_mem[int'(x) + (int'(y) / 8) * WIDTH];
          r.status    = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      cur_col = '0;
      cur_row = '0;
      font_w  = FONT_WIDTH_RESET;
      font_h  = FONT_HEIGHT_RESET;
      reply_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FONT_WIDTH) font_w = cfg_data[4:0];
        else if (cfg_index == REG_FONT_HEIGHT) font_h = cfg_data[6:0];
      end
      // check the result before queueing the new command, which cannot be answered yet
      if (out_valid && !out_stall) begin
        results_seen++;
        if (reply_q.size() == 0) begin
          report($sformatf("result %0d (status %0b data %02h) with nothing awaited",
                           results_seen, status, read_data));
        end else begin
          want = reply_q.pop_front();
          if (status !== want.status)
            report($sformatf("result %0d status: got %0b want %0b",
                             results_seen, status, want.status));
          if (read_data !== want.read_data)
            report($sformatf("result %0d read_data: got %02h want %02h",
                             results_seen, read_data, want.read_data));
        end
      end
      if (in_valid && !in_stall) reply_q.push_back(run_command());
    end
    pending = reply_q.size();
  end

endmodule

[tb/testbench.sv]
// Top of the pixel engine bench: clock, reset, command and configuration stimulus, result
// back-pressure and verdict. Depends on pfe_pkg, page_framebuffer_pixel_engine, pfe_frame_checker.
`timescale 1ns / 1ps

module testbench;
  import pfe_pkg::*;

  localparam logic [1:0] COLOR_NONE      = 2'd3;  // unused colour code
  localparam logic [2:0] CMD_UNUSED_LO   = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI   = 3'd7;
  localparam logic [1:0] REG_UNMAPPED    = 2'd3;
  localparam int         NUM_PHASES      = 8;
  localparam int         ITEMS_PER_PHASE = 220;
  localparam int         LONG_HOLD       = 300;
  localparam int         DRAIN_LIMIT     = 20000;
  localparam int         TAIL_CYCLES     = 50;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [7:0]  x;
  logic [6:0]  y;
  logic [1:0]  color;
  logic [7:0]  char_code;
  logic [15:0] row_bits;
  logic [5:0]  row_index;
  logic        out_valid;
  logic        out_stall;
  logic        status;
  logic [7:0]  read_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fail_count;
  int          pending;

  bit          burst;        // no idling on either side while set
  bit          rx_hold_req;  // asks the result side for one long hold-off
  int          issued;
  int unsigned cur_fw;
  int unsigned cur_fh;

  page_framebuffer_pixel_engine i_dut (.*);
  pfe_frame_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stall before each transaction, one long hold-off on request
  initial begin : result_side
    int hold;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold = LONG_HOLD;
        rx_hold_req = 1'b0;
      end else begin
        hold = burst ? 0 : $urandom_range(0, 10);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // called and returns at a falling edge
  task automatic send(input logic [2:0] c, input logic [7:0] px, input logic [6:0] py,
                      input logic [1:0] col, input logic [7:0] code, input logic [15:0] bits,
                      input logic [5:0] ri);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    x         <= px;
    y         <= py;
    color     <= col;
    char_code <= code;
    row_bits  <= bits;
    row_index <= ri;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    issued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FONT_WIDTH) cur_fw = val[4:0];
    else if (idx == REG_FONT_HEIGHT) cur_fh = val[6:0];
  endtask

  initial begin : stimulus
    int          pick;
    int          phase_end;
    int          phase_start;
    int          rows;
    int          waited;
    bit          broken;
    logic [7:0]  fw_val;
    logic [7:0]  fh_val;
    logic [7:0]  cx;
    logic [6:0]  cy;
    logic [7:0]  gcode;
    logic [7:0]  code;
    logic [1:0]  gcol;
    logic [5:0]  ri;

    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = '0;
    x           = '0;
    y           = '0;
    color       = '0;
    char_code   = '0;
    row_bits    = '0;
    row_index   = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    burst       = 1'b0;
    rx_hold_req = 1'b0;
    issued      = 0;
    cur_fw      = FONT_WIDTH_RESET;
    cur_fh      = FONT_HEIGHT_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset font 7 x 10
    send(CMD_READ, 8'd0, 7'd0, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_DRAW, 8'd0, 7'd0, PIX_ON, 8'd255, 16'hFFFF, 6'd63);
    send(CMD_DRAW, 8'd127, 7'd63, PIX_ON, 8'd0, 16'h0000, 6'd0);
    send(CMD_DRAW, 8'd127, 7'd63, PIX_FLIP, 8'd0, 16'h0000, 6'd0);
    send(CMD_DRAW, 8'd3, 7'd9, PIX_FLIP, 8'd0, 16'h0000, 6'd0);
    send(CMD_DRAW, 8'd3, 7'd9, COLOR_NONE, 8'd0, 16'h0000, 6'd0);
    send(CMD_READ, 8'd3, 7'd9, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_READ, 8'd127, 7'd63, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_DRAW, 8'd128, 7'd0, PIX_ON, 8'd0, 16'h0000, 6'd0);
    send(CMD_DRAW, 8'd255, 7'd127, PIX_ON, 8'd0, 16'h0000, 6'd0);
    send(CMD_DRAW, 8'd5, 7'd64, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_READ, 8'd200, 7'd0, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_READ, 8'd0, 7'd127, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_CURSOR, 8'd128, 7'd0, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_CURSOR, 8'd0, 7'd64, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    // glyph does not fit horizontally, then vertically
    send(CMD_CURSOR, 8'd121, 7'd0, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_GLYPH, 8'd0, 7'd0, PIX_ON, 8'd65, 16'hFFFF, 6'd0);
    send(CMD_CURSOR, 8'd10, 7'd55, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_GLYPH, 8'd0, 7'd0, PIX_ON, 8'd65, 16'hFFFF, 6'd0);
    send(CMD_CURSOR, 8'd10, 7'd54, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_GLYPH, 8'd0, 7'd0, PIX_ON, 8'd31, 16'hFFFF, 6'd0);
    send(CMD_GLYPH, 8'd0, 7'd0, PIX_ON, 8'd127, 16'hFFFF, 6'd0);
    send(CMD_GLYPH, 8'd0, 7'd0, PIX_ON, 8'd32, 16'hFFFF, 6'd0);
    send(CMD_GLYPH, 8'd0, 7'd0, PIX_ON, 8'd65, 16'hFFFF, 6'd10);
    // last row advances the cursor
    send(CMD_GLYPH, 8'd0, 7'd0, PIX_OFF, 8'd126, 16'hA5A5, 6'd9);
    send(CMD_READ, 8'd12, 7'd54, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_UNUSED_LO, 8'd0, 7'd0, PIX_ON, 8'd65, 16'hFFFF, 6'd0);
    send(CMD_UNUSED_HI, 8'd1, 7'd1, PIX_ON, 8'd65, 16'hFFFF, 6'd0);
    send(CMD_CLEAR, 8'd0, 7'd0, PIX_OFF, 8'd0, 16'h0000, 6'd0);
    send(CMD_READ, 8'd0, 7'd0, PIX_OFF, 8'd0, 16'h0000, 6'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin fw_val = 8'd7;  fh_val = 8'd10; end
        1: begin fw_val = 8'd1;  fh_val = 8'd1;  end
        2: begin fw_val = 8'd16; fh_val = 8'd64; end
        3: begin fw_val = 8'd0;  fh_val = 8'd8;  end
        4: begin fw_val = 8'hFF; fh_val = 8'd5;  end  // masks to 31: bits past 15 read 0
        5: begin fw_val = 8'hE5; fh_val = 8'h80; end  // height masks to 0
        6: begin fw_val = 8'd12; fh_val = 8'd70; end  // taller than the panel
        default: begin fw_val = 8'd3; fh_val = 8'd7; end
      endcase
      write_reg(REG_FONT_WIDTH, fw_val);
      write_reg(REG_FONT_HEIGHT, fh_val);
      if (p == NUM_PHASES - 1) write_reg(REG_UNMAPPED, 8'($urandom));  // must be ignored
      phase_start = issued;
      phase_end   = issued + ITEMS_PER_PHASE;
      if (p == 1) rx_hold_req = 1'b1;
      while (issued < phase_end) begin
        burst = (p == 1 && issued < phase_start + 40) || ((issued / 64) % 4 == 3);
        pick  = $urandom_range(0, 99);
        if (pick < 30) begin
          // one character: cursor (most times), then its rows, sometimes a broken sequence
          cx = 8'($urandom_range(0, 127 - cur_fw));
          cy = (cur_fh == 0 || cur_fh > 64) ? 7'($urandom_range(0, 63))
                                            : 7'($urandom_range(0, 64 - cur_fh));
          rows = (cur_fh == 0) ? 1 : (cur_fh > 64 ? 3 : int'(cur_fh));
          if ($urandom_range(0, 9) < 7)
            send(CMD_CURSOR, cx, cy, 2'($urandom), 8'($urandom), 16'($urandom), 6'($urandom));
          gcode  = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
          gcol   = ($urandom_range(0, 9) == 0) ? COLOR_NONE : 2'($urandom_range(0, 2));
          broken = ($urandom_range(0, 7) == 0);
          for (int r = 0; r < rows; r++) begin
            code = gcode;
            ri   = 6'(r);
            if (broken && $urandom_range(0, 3) == 0) begin
              if ($urandom_range(0, 1) == 0) code = 8'($urandom_range(0, CHAR_FIRST - 1));
              else ri = 6'($urandom);
            end
            send(CMD_GLYPH, 8'($urandom), 7'($urandom), gcol, code, 16'($urandom), ri);
          end
          send(CMD_READ, 8'(cx + $urandom_range(0, cur_fw)), 7'(cy + $urandom_range(0, rows - 1)),
               2'($urandom), 8'($urandom), 16'($urandom), 6'($urandom));
        end else if (pick < 55) begin
          cx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
          cy = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 63));
          send(CMD_DRAW, cx, cy, 2'($urandom), 8'($urandom), 16'($urandom), 6'($urandom));
          if ($urandom_range(0, 1) == 0)
            send(CMD_READ, cx, cy, 2'($urandom), 8'($urandom), 16'($urandom), 6'($urandom));
        end else if (pick < 80) begin
          cx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
          cy = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 63));
          send(CMD_READ, cx, cy, 2'($urandom), 8'($urandom), 16'($urandom), 6'($urandom));
        end else if (pick < 88) begin
          send(CMD_CURSOR, 8'($urandom), 7'($urandom), 2'($urandom), 8'($urandom),
               16'($urandom), 6'($urandom));
        end else if (pick < 94) begin
          send(CMD_GLYPH, 8'($urandom), 7'($urandom), 2'($urandom), 8'($urandom),
               16'($urandom), 6'($urandom));
        end else if (pick < 97) begin
          send(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), 8'($urandom), 7'($urandom),
               2'($urandom), 8'($urandom), 16'($urandom), 6'($urandom));
        end else if (pick < 98) begin
          send(CMD_CLEAR, 8'($urandom), 7'($urandom), 2'($urandom), 8'($urandom),
               16'($urandom), 6'($urandom));
        end else begin
          send(CMD_READ, 8'($urandom_range(0, 127)), 7'($urandom_range(0, 63)), 2'($urandom),
               8'($urandom), 16'($urandom), 6'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    burst = 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
